### rtl/manifest_record_scanner_macros.svh
// Assertion helpers for the manifest record scanner.
// Every property is clocked on clk; the first two are disabled while rst is high.
`ifndef MANIFEST_RECORD_SCANNER_MACROS_SVH
`define MANIFEST_RECORD_SCANNER_MACROS_SVH

// Same-cycle implication outside reset
`define MRS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication outside reset
`define MRS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Condition that must hold in the cycle after a reset cycle
`define MRS_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) $past(rst) |-> (cons)) \
    else $error("post-reset condition failed");

`endif

### rtl/mrs_pkg.sv
package mrs_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 64;
  localparam int unsigned WORD_W         = 32;
  localparam int unsigned SIZE_W         = 24;
  localparam int unsigned SLOT_IDX_W     = 6;
  localparam int unsigned WPOS_W         = 3;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam int unsigned QPTR_W         = 1;
  localparam int unsigned QCNT_W         = 2;
  localparam int unsigned PADDR_W        = 5;
  localparam int unsigned PDATA_W        = 32;

  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] MIN_SIZE = 32'd8;

  // Register reset values
  localparam logic [WORD_W-1:0] RST_MAGIC    = 32'h3156_4741;
  localparam logic [WORD_W-1:0] RST_FORMAT   = 32'd2;
  localparam logic [WORD_W-1:0] RST_BOARD    = 32'hF103_0101;
  localparam logic [WORD_W-1:0] RST_BASE     = 32'h0800_4000;
  localparam logic [SIZE_W-1:0] RST_MAX_SIZE = 24'h03_A000;

  // Register indexes
  localparam logic [2:0] REG_MAGIC    = 3'd0;
  localparam logic [2:0] REG_FORMAT   = 3'd1;
  localparam logic [2:0] REG_BOARD    = 3'd2;
  localparam logic [2:0] REG_BASE     = 3'd3;
  localparam logic [2:0] REG_MAX_SIZE = 3'd4;

  // Word positions inside a record
  localparam logic [WPOS_W-1:0] WP_MAGIC  = 3'd0;
  localparam logic [WPOS_W-1:0] WP_FORMAT = 3'd1;
  localparam logic [WPOS_W-1:0] WP_BASE   = 3'd2;
  localparam logic [WPOS_W-1:0] WP_SIZE   = 3'd3;
  localparam logic [WPOS_W-1:0] WP_ICRC   = 3'd4;
  localparam logic [WPOS_W-1:0] WP_HCRC   = 3'd5;
  localparam logic [WPOS_W-1:0] WP_GEN    = 3'd6;
  localparam logic [WPOS_W-1:0] WP_BOARD  = 3'd7;
  // Header CRC covers the words ahead of the header CRC word
  localparam logic [WPOS_W-1:0] CRC_WORDS = WP_HCRC;

  typedef struct packed {
    logic [WORD_W-1:0] magic;
    logic [WORD_W-1:0] format;
    logic [WORD_W-1:0] board;
    logic [WORD_W-1:0] base;
    logic [SIZE_W-1:0] max_size;
  } cfg_t;

  // Summary of one finished slot, handed from the classifier to the tracker
  typedef struct packed {
    logic                  clear;
    logic [SLOT_IDX_W-1:0] idx;
    logic                  erased;
    logic                  fields_ok;
    logic [SIZE_W-1:0]     size;
    logic [WORD_W-1:0]     image_crc;
    logic [WORD_W-1:0]     generation;
  } slot_sum_t;

  // Reflected CRC-32 over one word fed as four little-endian bytes; the bit loop
  // flattens into a fixed XOR network.
  function automatic logic [WORD_W-1:0] crc_word(input logic [WORD_W-1:0] crc,
                                                 input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = crc ^ w;
    for (int i = 0; i < WORD_W; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {WORD_W{c[0]}});
    end
    return c;
  endfunction

endpackage

### rtl/mrs_front.sv
module mrs_front #(
  parameter int unsigned SLOT_COUNT = mrs_pkg::DEF_SLOT_COUNT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [mrs_pkg::WORD_W-1:0]    word,
  input  logic                          start_req,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mrs_pkg::cfg_t                 cfg,
  input  logic                          q_full,
  output logic                          push,
  output mrs_pkg::slot_sum_t            push_data
);
  import mrs_pkg::*;

  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1);

  logic [WPOS_W-1:0] word_pos;
  logic [CNT_W-1:0]  cur_slot;
  logic [WORD_W-1:0] crc;
  logic              all_ones;
  logic              fields_ok;
  logic [SIZE_W-1:0] slot_size;
  logic [WORD_W-1:0] slot_icrc;
  logic [WORD_W-1:0] slot_gen;
  logic              pending_clear;

  logic [WPOS_W-1:0] eff_pos;
  logic [CNT_W-1:0]  eff_slot;
  logic [WORD_W-1:0] eff_crc;
  logic              eff_all;
  logic              eff_ok;
  logic [SIZE_W-1:0] eff_size;
  logic [WORD_W-1:0] eff_icrc;
  logic [WORD_W-1:0] eff_gen;
  logic              ok_next;
  logic              all_next;
  logic [WORD_W-1:0] crc_next;
  logic              accept;
  logic              active;
  logic              last;

  // Take a word whenever the queue has room for a possible summary
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Start of scan: classify this word against freshly cleared slot state
  always_comb begin
    if (start_req) begin
      eff_pos  = WP_MAGIC;
      eff_slot = '0;
      eff_crc  = ALL_ONES;
      eff_all  = 1'b1;
      eff_ok   = 1'b1;
      eff_size = '0;
      eff_icrc = '0;
      eff_gen  = '0;
    end else begin
      eff_pos  = word_pos;
      eff_slot = cur_slot;
      eff_crc  = crc;
      eff_all  = all_ones;
      eff_ok   = fields_ok;
      eff_size = slot_size;
      eff_icrc = slot_icrc;
      eff_gen  = slot_gen;
    end
  end

  assign active   = eff_slot < CNT_W'(SLOT_COUNT);
  assign last     = eff_pos == WP_BOARD;
  assign all_next = eff_all && (word == ALL_ONES);
  assign crc_next = (eff_pos < CRC_WORDS) ? crc_word(eff_crc, word) : eff_crc;

  // Check the field that this word position carries
  always_comb begin
    ok_next = eff_ok;
    case (eff_pos)
      WP_MAGIC:  if (word != cfg.magic) ok_next = 1'b0;
      WP_FORMAT: if (word != cfg.format) ok_next = 1'b0;
      WP_BASE:   if (word != cfg.base) ok_next = 1'b0;
      WP_SIZE: begin
        if (word < MIN_SIZE || word > {{(WORD_W - SIZE_W){1'b0}}, cfg.max_size}) begin
          ok_next = 1'b0;
        end
      end
      WP_ICRC:   ok_next = eff_ok;
      WP_HCRC:   if ((eff_crc ^ ALL_ONES) != word) ok_next = 1'b0;
      WP_GEN:    ok_next = eff_ok;
      WP_BOARD:  if (word != cfg.board) ok_next = 1'b0;
      default:   ok_next = eff_ok;
    endcase
  end

  // Hand the finished slot to the tracker on its eighth word
  assign push                 = accept && active && last;
  assign push_data.clear      = pending_clear || start_req;
  assign push_data.idx        = SLOT_IDX_W'(eff_slot);
  assign push_data.erased     = all_next;
  assign push_data.fields_ok  = ok_next;
  assign push_data.size       = eff_size;
  assign push_data.image_crc  = eff_icrc;
  assign push_data.generation = eff_gen;

  // Advance slot state
  always_ff @(posedge clk) begin
    if (rst) begin
      word_pos      <= WP_MAGIC;
      cur_slot      <= '0;
      crc           <= ALL_ONES;
      all_ones      <= 1'b1;
      fields_ok     <= 1'b1;
      pending_clear <= 1'b0;
    end else if (accept && active) begin
      if (last) begin
        word_pos      <= WP_MAGIC;
        cur_slot      <= eff_slot + CNT_W'(1);
        crc           <= ALL_ONES;
        all_ones      <= 1'b1;
        fields_ok     <= 1'b1;
        pending_clear <= 1'b0;
      end else begin
        word_pos      <= eff_pos + WPOS_W'(1);
        cur_slot      <= eff_slot;
        crc           <= crc_next;
        all_ones      <= all_next;
        fields_ok     <= ok_next;
        pending_clear <= pending_clear || start_req;
      end
    end
  end

  // Capture record payload words
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_size <= '0;
      slot_icrc <= '0;
      slot_gen  <= '0;
    end else if (accept && active) begin
      slot_size <= (eff_pos == WP_SIZE) ? word[SIZE_W-1:0] : eff_size;
      slot_icrc <= (eff_pos == WP_ICRC) ? word : eff_icrc;
      slot_gen  <= (eff_pos == WP_GEN) ? word : eff_gen;
    end
  end

endmodule

### rtl/mrs_queue.sv
module mrs_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  mrs_pkg::slot_sum_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output mrs_pkg::slot_sum_t head
);
  import mrs_pkg::*;

  slot_sum_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = mem[rd_ptr];

  // Store incoming summaries
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/mrs_back.sv
module mrs_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  mrs_pkg::slot_sum_t               q_head,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mrs_pkg::SLOT_IDX_W-1:0]   slot_index,
  output logic                             slot_erased,
  output logic                             slot_valid,
  output logic                             scan_stopped,
  output logic                             have_latest,
  output logic [mrs_pkg::SIZE_W-1:0]       latest_size,
  output logic [mrs_pkg::WORD_W-1:0]       latest_image_crc,
  output logic [mrs_pkg::WORD_W-1:0]       latest_generation,
  output logic                             free_found,
  output logic [mrs_pkg::SLOT_IDX_W-1:0]   free_index
);
  import mrs_pkg::*;

  logic                  best_valid;
  logic [SIZE_W-1:0]     best_size;
  logic [WORD_W-1:0]     best_icrc;
  logic [WORD_W-1:0]     best_gen;
  logic                  stopped;
  logic [SLOT_IDX_W-1:0] free_slot;

  logic                  eff_best_valid;
  logic [SIZE_W-1:0]     eff_best_size;
  logic [WORD_W-1:0]     eff_best_icrc;
  logic [WORD_W-1:0]     eff_best_gen;
  logic                  eff_stopped;
  logic [SLOT_IDX_W-1:0] eff_free;
  logic                  take_free;
  logic                  take_best;

  // Pop when the output register is empty or being emptied
  assign pop = q_valid && (!out_valid || out_ready);

  // New scan: drop tracker state before this slot
  always_comb begin
    if (q_head.clear) begin
      eff_best_valid = 1'b0;
      eff_best_size  = '0;
      eff_best_icrc  = '0;
      eff_best_gen   = '0;
      eff_stopped    = 1'b0;
      eff_free       = '0;
    end else begin
      eff_best_valid = best_valid;
      eff_best_size  = best_size;
      eff_best_icrc  = best_icrc;
      eff_best_gen   = best_gen;
      eff_stopped    = stopped;
      eff_free       = free_slot;
    end
  end

  assign take_free = !eff_stopped && q_head.erased;
  assign take_best = !eff_stopped && !q_head.erased && q_head.fields_ok;

  // Update latest record and free slot
  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_size  <= '0;
      best_icrc  <= '0;
      best_gen   <= '0;
      stopped    <= 1'b0;
      free_slot  <= '0;
    end else if (pop) begin
      best_valid <= eff_best_valid || take_best;
      best_size  <= take_best ? q_head.size : eff_best_size;
      best_icrc  <= take_best ? q_head.image_crc : eff_best_icrc;
      best_gen   <= take_best ? q_head.generation : eff_best_gen;
      stopped    <= eff_stopped || take_free;
      free_slot  <= take_free ? q_head.idx : eff_free;
    end
  end

  // Hold the per-slot result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      slot_index  <= q_head.idx;
      slot_erased <= q_head.erased;
      slot_valid  <= take_best;
    end
  end

  // Tracker state only moves together with the output register
  assign scan_stopped      = stopped;
  assign free_found        = stopped;
  assign free_index        = free_slot;
  assign have_latest       = best_valid;
  assign latest_size       = best_size;
  assign latest_image_crc  = best_icrc;
  assign latest_generation = best_gen;

endmodule

### rtl/manifest_record_scanner.sv
// Manifest record scanner: takes one 32-bit manifest word per cycle (in_valid /
// in_ready) and, on the eighth word of every slot below SLOT_COUNT, gives one
// per-slot result with the running latest-record and free-slot status. The front
// end checks each word as it arrives, including a one-word CRC-32 step, so the
// sustained input rate is one word per cycle; after its slot's last word is
// accepted, a result passes a two-entry summary queue and the tracker stage into
// the output register. in_ready drops only while that queue is full, which
// happens only when the result side stalls. Registers sit on an APB port at
// byte addresses 0x00 magic, 0x04 format, 0x08 board id, 0x0C image base and
// 0x10 maximum image size; they are meant to be written while no scan is running.
module manifest_record_scanner #(
  parameter int unsigned SLOT_COUNT = mrs_pkg::DEF_SLOT_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  // APB configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mrs_pkg::PADDR_W-1:0]      paddr,
  input  logic [mrs_pkg::PDATA_W-1:0]      pwdata,
  output logic [mrs_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  // Word input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mrs_pkg::WORD_W-1:0]       word,
  input  logic                             start_req,
  // Slot results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mrs_pkg::SLOT_IDX_W-1:0]   slot_index,
  output logic                             slot_erased,
  output logic                             slot_valid,
  output logic                             scan_stopped,
  output logic                             have_latest,
  output logic [mrs_pkg::SIZE_W-1:0]       latest_size,
  output logic [mrs_pkg::WORD_W-1:0]       latest_image_crc,
  output logic [mrs_pkg::WORD_W-1:0]       latest_generation,
  output logic                             free_found,
  output logic [mrs_pkg::SLOT_IDX_W-1:0]   free_index
);
  import mrs_pkg::*;

  `include "manifest_record_scanner_macros.svh"

  cfg_t      cfg;
  logic      cfg_wr;
  logic [2:0] reg_idx;
  logic      push;
  logic      q_full;
  logic      pop;
  logic      q_valid;
  slot_sum_t push_data;
  slot_sum_t q_head;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic    <= RST_MAGIC;
      cfg.format   <= RST_FORMAT;
      cfg.board    <= RST_BOARD;
      cfg.base     <= RST_BASE;
      cfg.max_size <= RST_MAX_SIZE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAGIC:    cfg.magic    <= pwdata;
        REG_FORMAT:   cfg.format   <= pwdata;
        REG_BOARD:    cfg.board    <= pwdata;
        REG_BASE:     cfg.base     <= pwdata;
        REG_MAX_SIZE: cfg.max_size <= pwdata[SIZE_W-1:0];
        default:      cfg.magic    <= cfg.magic;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (reg_idx)
      REG_MAGIC:    prdata = cfg.magic;
      REG_FORMAT:   prdata = cfg.format;
      REG_BOARD:    prdata = cfg.board;
      REG_BASE:     prdata = cfg.base;
      REG_MAX_SIZE: prdata = {{(PDATA_W - SIZE_W){1'b0}}, cfg.max_size};
      default:      prdata = '0;
    endcase
  end

  mrs_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .start_req (start_req),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mrs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  mrs_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .slot_index        (slot_index),
    .slot_erased       (slot_erased),
    .slot_valid        (slot_valid),
    .scan_stopped      (scan_stopped),
    .have_latest       (have_latest),
    .latest_size       (latest_size),
    .latest_image_crc  (latest_image_crc),
    .latest_generation (latest_generation),
    .free_found        (free_found),
    .free_index        (free_index)
  );

  // A summary is never pushed into a full queue
  `MRS_ASSERT_IMPL(a_queue_no_overflow, push, !q_full)
  // A valid slot always leaves a latest record behind
  `MRS_ASSERT_IMPL(a_valid_sets_latest, out_valid && slot_valid, have_latest && !slot_erased)
  // Once stopped, the search stays stopped until a new scan starts or reset
  `MRS_ASSERT_IMPL(a_stop_sticky, $fell(scan_stopped), $past(pop && q_head.clear) || $past(rst))
  // Nothing is offered right after reset
  `MRS_ASSERT_AFTER_RESET(a_reset_idle, !out_valid && !q_valid)

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mrs_pkg::*;

  localparam int SLOTS        = DEF_SLOT_COUNT;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_WORDS = 1850;

  typedef enum {
    K_VALID, K_BAD_MAGIC, K_BAD_FORMAT, K_BAD_BASE, K_SIZE_LOW, K_SIZE_HIGH,
    K_SIZE_WIDE, K_BAD_HCRC, K_BAD_BOARD, K_ERASED, K_NEAR_ERASED, K_NOISE
  } slot_kind_t;

  typedef enum {CFG_DEFAULT, CFG_RANDOM, CFG_LOW, CFG_HIGH, CFG_TWEAK} cfg_mode_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              start;
  } word_item_t;

  typedef struct {
    logic [SLOT_IDX_W-1:0] slot_index;
    logic                  slot_erased;
    logic                  slot_valid;
    logic                  scan_stopped;
    logic                  have_latest;
    logic [SIZE_W-1:0]     latest_size;
    logic [WORD_W-1:0]     latest_image_crc;
    logic [WORD_W-1:0]     latest_generation;
    logic                  free_found;
    logic [SLOT_IDX_W-1:0] free_index;
  } slot_report_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WORD_W-1:0]     word = '0;
  logic                  start_req = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic                  slot_erased;
  logic                  slot_valid;
  logic                  scan_stopped;
  logic                  have_latest;
  logic [SIZE_W-1:0]     latest_size;
  logic [WORD_W-1:0]     latest_image_crc;
  logic [WORD_W-1:0]     latest_generation;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_index;

  word_item_t   words_to_send[$];
  slot_report_t reports_due[$];
  int unsigned  words_queued = 0;
  int unsigned  words_accepted = 0;
  int           mismatches = 0;
  int           stall_pct = 0;
  int           send_gap = 0;
  int           hold_left = 0;
  int           long_holds_asked = 0;
  int           long_holds_done = 0;
  int           cycle_count = 0;

  // Scanner mirror: registers and scan state
  cfg_t                  cfg;
  logic [WPOS_W-1:0]     wpos;
  logic [6:0]            cur_slot;
  logic [WORD_W-1:0]     crc_acc;
  logic                  ones_so_far;
  logic                  hdr_ok;
  logic [WORD_W-1:0]     rec_size;
  logic [WORD_W-1:0]     rec_icrc;
  logic [WORD_W-1:0]     rec_gen;
  logic                  best_valid;
  logic [SIZE_W-1:0]     best_size;
  logic [WORD_W-1:0]     best_icrc;
  logic [WORD_W-1:0]     best_gen;
  logic                  stopped;
  logic [SLOT_IDX_W-1:0] free_slot;

  manifest_record_scanner DUT (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .word              (word),
    .start_req         (start_req),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .slot_index        (slot_index),
    .slot_erased       (slot_erased),
    .slot_valid        (slot_valid),
    .scan_stopped      (scan_stopped),
    .have_latest       (have_latest),
    .latest_size       (latest_size),
    .latest_image_crc  (latest_image_crc),
    .latest_generation (latest_generation),
    .free_found        (free_found),
    .free_index        (free_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reflected CRC-32, one little-endian byte at a time
  function automatic logic [WORD_W-1:0] crc32_step(input logic [WORD_W-1:0] crc,
                                                   input logic [WORD_W-1:0] w);
    logic [WORD_W-1:0] c;
    c = crc;
    for (int b = 0; b < 4; b++) begin
      c = c ^ {24'h0, w[8*b +: 8]};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void clear_slot();
    wpos        = '0;
    crc_acc     = ALL_ONES;
    ones_so_far = 1'b1;
    hdr_ok      = 1'b1;
    rec_size    = '0;
    rec_icrc    = '0;
    rec_gen     = '0;
  endfunction

  function automatic void clear_scan();
    clear_slot();
    cur_slot   = '0;
    best_valid = 1'b0;
    best_size  = '0;
    best_icrc  = '0;
    best_gen   = '0;
    stopped    = 1'b0;
    free_slot  = '0;
  endfunction

  // Advance the mirror by one word; returns 1 when the word completes a slot
  function automatic bit scan_word(input logic [WORD_W-1:0] w, input logic start,
                                   output slot_report_t rep);
    logic erased;
    logic valid;
    if (start) clear_scan();
    if (cur_slot >= SLOTS) return 1'b0;
    if (w != ALL_ONES) ones_so_far = 1'b0;
    case (wpos)
      WP_MAGIC:  if (w != cfg.magic) hdr_ok = 1'b0;
      WP_FORMAT: if (w != cfg.format) hdr_ok = 1'b0;
      WP_BASE:   if (w != cfg.base) hdr_ok = 1'b0;
      WP_SIZE: begin
        rec_size = w;
        if (w < MIN_SIZE || w > {8'h00, cfg.max_size}) hdr_ok = 1'b0;
      end
      WP_ICRC:   rec_icrc = w;
      WP_HCRC:   if (~crc_acc != w) hdr_ok = 1'b0;
      WP_GEN:    rec_gen = w;
      default:   if (w != cfg.board) hdr_ok = 1'b0;
    endcase
    if (wpos < CRC_WORDS) crc_acc = crc32_step(crc_acc, w);
    if (wpos != WP_BOARD) begin
      wpos = wpos + 1'b1;
      return 1'b0;
    end

    // Last word of the slot: update latest and free status
    erased = ones_so_far;
    valid  = 1'b0;
    if (!stopped) begin
      if (erased) begin
        stopped   = 1'b1;
        free_slot = cur_slot[SLOT_IDX_W-1:0];
      end else if (hdr_ok) begin
        valid      = 1'b1;
        best_valid = 1'b1;
        best_size  = rec_size[SIZE_W-1:0];
        best_icrc  = rec_icrc;
        best_gen   = rec_gen;
      end
    end
    rep.slot_index        = cur_slot[SLOT_IDX_W-1:0];
    rep.slot_erased       = erased;
    rep.slot_valid        = valid;
    rep.scan_stopped      = stopped;
    rep.have_latest       = best_valid;
    rep.latest_size       = best_size;
    rep.latest_image_crc  = best_icrc;
    rep.latest_generation = best_gen;
    rep.free_found        = stopped;
    rep.free_index        = free_slot;
    clear_slot();
    cur_slot = cur_slot + 1'b1;
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Offer queued words, with random gaps
  always @(posedge clk) begin : drive_words
    slot_report_t rep;
    word_item_t   nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        words_accepted++;
        if (scan_word(word, start_req, rep)) reports_due.push_back(rep);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if ($urandom_range(99) < stall_pct) begin
          send_gap = $urandom_range(17);
          in_valid <= 1'b0;
        end else begin
          nxt = words_to_send.pop_front();
          in_valid  <= 1'b1;
          word      <= nxt.word;
          start_req <= nxt.start;
        end
      end
    end
  end

  // Compare slot results and throttle out_ready
  always @(posedge clk) begin : check_reports
    slot_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (reports_due.size() == 0) begin
          $error("slot result arrived with nothing expected");
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("slot_index", 32'(want.slot_index), 32'(slot_index));
          check_field("slot_erased", 32'(want.slot_erased), 32'(slot_erased));
          check_field("slot_valid", 32'(want.slot_valid), 32'(slot_valid));
          check_field("scan_stopped", 32'(want.scan_stopped), 32'(scan_stopped));
          check_field("have_latest", 32'(want.have_latest), 32'(have_latest));
          check_field("latest_size", 32'(want.latest_size), 32'(latest_size));
          check_field("latest_image_crc", want.latest_image_crc, latest_image_crc);
          check_field("latest_generation", want.latest_generation, latest_generation);
          check_field("free_found", 32'(want.free_found), 32'(free_found));
          check_field("free_index", 32'(want.free_index), 32'(free_index));
        end
      end
      if (long_holds_done != long_holds_asked) begin
        long_holds_done++;
        hold_left = LONG_HOLD;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        hold_left = $urandom_range(17);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic logic [WORD_W-1:0] flip_bit();
    return 32'h1 << $urandom_range(31);
  endfunction

  function automatic logic [WORD_W-1:0] any_word();
    case ($urandom_range(5))
      0:       return '0;
      1:       return ALL_ONES;
      default: return $urandom;
    endcase
  endfunction

  function automatic slot_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return K_VALID;
    if (r < 56) return K_ERASED;
    if (r < 60) return K_NEAR_ERASED;
    if (r < 64) return K_NOISE;
    return slot_kind_t'($urandom_range(K_BAD_BOARD, K_BAD_MAGIC));
  endfunction

  function automatic void push_word(input logic [WORD_W-1:0] w, input logic s);
    words_to_send.push_back('{word: w, start: s});
    words_queued++;
  endfunction

  // Build one record for the current registers, then break it as asked
  task automatic push_slot(input slot_kind_t kind, input logic start);
    logic [WORD_W-1:0] w [8];
    logic [WORD_W-1:0] max32;
    logic [WORD_W-1:0] crc;
    max32 = {8'h00, cfg.max_size};
    w[WP_MAGIC]  = cfg.magic;
    w[WP_FORMAT] = cfg.format;
    w[WP_BASE]   = cfg.base;
    case ($urandom_range(3))
      0:       w[WP_SIZE] = MIN_SIZE;
      1:       w[WP_SIZE] = max32;
      default: w[WP_SIZE] = $urandom_range(max32, MIN_SIZE);
    endcase
    w[WP_ICRC]  = any_word();
    w[WP_GEN]   = any_word();
    w[WP_BOARD] = cfg.board;
    // break a covered field before the CRC so the header CRC still matches
    case (kind)
      K_BAD_MAGIC:  w[WP_MAGIC]  = w[WP_MAGIC] ^ flip_bit();
      K_BAD_FORMAT: w[WP_FORMAT] = w[WP_FORMAT] ^ flip_bit();
      K_BAD_BASE:   w[WP_BASE]   = w[WP_BASE] ^ flip_bit();
      K_SIZE_LOW:   w[WP_SIZE]   = $urandom_range(MIN_SIZE - 1);
      K_SIZE_HIGH:  w[WP_SIZE]   = max32 + $urandom_range(1000, 1);
      K_SIZE_WIDE:  w[WP_SIZE]   = {8'($urandom_range(255, 1)), 24'($urandom)};
      default: ;
    endcase
    crc = ALL_ONES;
    for (int i = 0; i < CRC_WORDS; i++) crc = crc32_step(crc, w[i]);
    w[WP_HCRC] = ~crc;
    case (kind)
      K_BAD_HCRC:  w[WP_HCRC]  = w[WP_HCRC] ^ flip_bit();
      K_BAD_BOARD: w[WP_BOARD] = w[WP_BOARD] ^ flip_bit();
      K_ERASED:    foreach (w[i]) w[i] = ALL_ONES;
      K_NEAR_ERASED: begin
        foreach (w[i]) w[i] = ALL_ONES;
        w[$urandom_range(7)] = ALL_ONES ^ flip_bit();
      end
      K_NOISE:     foreach (w[i]) w[i] = $urandom;
      default: ;
    endcase
    for (int i = 0; i < 8; i++) push_word(w[i], start && i == 0);
  endtask

  // Queue a run of slots; sometimes trail a partial record
  task automatic push_scan(input logic start, input int slots, input logic erase_ok);
    slot_kind_t kind;
    for (int s = 0; s < slots; s++) begin
      kind = pick_kind();
      if (!erase_ok && kind == K_ERASED) kind = K_VALID;
      push_slot(kind, start && s == 0);
    end
    if ($urandom_range(5) == 0) repeat ($urandom_range(7, 1)) push_word(any_word(), 1'b0);
  endtask

  // Hold until every word is taken and every result is back
  task automatic drain();
    while (words_accepted != words_queued || reports_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAGIC:    cfg.magic    = value;
      REG_FORMAT:   cfg.format   = value;
      REG_BOARD:    cfg.board    = value;
      REG_BASE:     cfg.base     = value;
      REG_MAX_SIZE: cfg.max_size = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input cfg_mode_t mode);
    logic [2:0] idx;
    case (mode)
      CFG_DEFAULT: begin
        write_reg(REG_MAGIC, RST_MAGIC);
        write_reg(REG_FORMAT, RST_FORMAT);
        write_reg(REG_BOARD, RST_BOARD);
        write_reg(REG_BASE, RST_BASE);
        write_reg(REG_MAX_SIZE, {8'h00, RST_MAX_SIZE});
      end
      CFG_RANDOM: begin
        write_reg(REG_MAGIC, $urandom);
        write_reg(REG_FORMAT, $urandom);
        write_reg(REG_BOARD, $urandom);
        write_reg(REG_BASE, $urandom);
        write_reg(REG_MAX_SIZE, $urandom_range(24'hFF_FFFF, 8));
      end
      CFG_LOW: begin
        write_reg(REG_MAGIC, '0);
        write_reg(REG_FORMAT, '0);
        write_reg(REG_BOARD, '0);
        write_reg(REG_BASE, '0);
        write_reg(REG_MAX_SIZE, MIN_SIZE);
      end
      CFG_HIGH: begin
        write_reg(REG_MAGIC, ALL_ONES);
        write_reg(REG_FORMAT, ALL_ONES);
        write_reg(REG_BOARD, ALL_ONES);
        write_reg(REG_BASE, ALL_ONES);
        write_reg(REG_MAX_SIZE, 32'h00FF_FFFF);
      end
      default: begin
        idx = 3'($urandom_range(4));
        if (idx == REG_MAX_SIZE) write_reg(idx, $urandom_range(24'hFF_FFFF, 8));
        else write_reg(idx, $urandom);
      end
    endcase
  endtask

  initial begin : run_scans
    int phase;
    cfg = '{magic: RST_MAGIC, format: RST_FORMAT, board: RST_BOARD, base: RST_BASE,
            max_size: RST_MAX_SIZE};
    clear_scan();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: valid record, oversized size word, then an erased slot
    stall_pct = 20;
    push_slot(K_VALID, 1'b1);
    push_slot(K_SIZE_WIDE, 1'b0);
    push_slot(K_ERASED, 1'b0);
    drain();

    // Random phases, registers rewritten between them while idle
    phase = 0;
    while (words_queued < RANDOM_WORDS) begin
      case ($urandom_range(2))
        0:       stall_pct = 0;
        1:       stall_pct = 5;
        default: stall_pct = 25;
      endcase
      case (phase)
        0: ;
        1: set_config(CFG_RANDOM);
        2: set_config(CFG_LOW);
        3: set_config(CFG_HIGH);
        default: set_config($urandom_range(3) == 0 ? CFG_DEFAULT : CFG_TWEAK);
      endcase
      if (phase == 1) begin
        // run past the last slot; stall the result side so the input backs up
        push_scan(1'b1, SLOTS + 1, 1'($urandom_range(1)));
        long_holds_asked++;
      end else begin
        repeat ($urandom_range(4, 1))
          push_scan($urandom_range(3) != 0, $urandom_range(12, 1), 1'b1);
      end
      drain();
      phase++;
    end

    // Closing stretch with no idling on either side
    stall_pct = 0;
    send_gap  = 0;
    hold_left = 0;
    push_scan(1'b1, $urandom_range(6, 3), 1'b1);
    drain();

    if (mismatches == 0 && reports_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/mrs_pkg.sv
rtl/mrs_front.sv
rtl/mrs_queue.sv
rtl/mrs_back.sv
rtl/manifest_record_scanner.sv
verif/testbench.sv
